/* hdl/utli_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// utli_pkg
// Shared types and constants of the uniform-grid interpolation table.
// ----------------------------------------------------------------------------
package utli_pkg;

    localparam int TABLE_DEPTH = 1024;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);

    localparam int DATA_W      = 32;
    localparam int ENTRY_IDX_W = 10;
    localparam int SIZE_W      = 11;
    localparam int FRAC_W      = 16;

    // input tdata: query_x, entry_index, entry_value, zero padded to bytes
    localparam int S_FIELDS_W  = DATA_W + ENTRY_IDX_W + DATA_W;
    localparam int S_TDATA_W   = ((S_FIELDS_W + 7) / 8) * 8;

    // operation codes
    localparam logic OP_QUERY = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    // register indexes (byte address / 4)
    localparam logic [1:0] REG_LOWER_BOUND  = 2'd0;
    localparam logic [1:0] REG_UPPER_BOUND  = 2'd1;
    localparam logic [1:0] REG_TABLE_SIZE   = 2'd2;
    localparam logic [1:0] REG_STEP_INVERSE = 2'd3;

    localparam logic signed [DATA_W-1:0] LOWER_BOUND_RST  = 32'sd0;
    localparam logic signed [DATA_W-1:0] UPPER_BOUND_RST  = 32'sd67043328;
    localparam logic [SIZE_W-1:0]        TABLE_SIZE_RST   = 11'd1024;
    localparam logic [DATA_W-1:0]        STEP_INVERSE_RST = 32'd65536;

    typedef struct packed {
        logic signed [DATA_W-1:0] lower_bound;
        logic signed [DATA_W-1:0] upper_bound;
        logic [SIZE_W-1:0]        table_size;
        logic [DATA_W-1:0]        step_inverse;
    } utli_cfg_t;

endpackage
`default_nettype wire

/* hdl/uniform_table_linear_interpolator_top.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// uniform_table_linear_interpolator_top
// Uniform-grid lookup table with linear blending, APB register block.
// ----------------------------------------------------------------------------
//  channel   | direction | contents
//  s_*       | in        | tuser: operation; tdata: query_x, entry_index,
//            |           |   entry_value (from bit 0 up)
//  m_*       | out       | tuser: in_range; tdata: result_value
//  APB       | in/out    | lower_bound, upper_bound, table_size, step_inverse
//
//  One item per cycle unless m_tready stalls; a query result reaches m_*
//  through the offset, multiply, sample memory read, blend multiply and
//  output stage registers, in that order.
//  The sample memory has one write and two read ports so both neighbors
//  come from a single access. Writes give no result.
//  rst_n clears control and registers; the sample table is not cleared.
//  A stall on m_tready holds stages that are full; empty stages still fill.
// ----------------------------------------------------------------------------
module uniform_table_linear_interpolator_top
(
    input  wire                                clk,
    input  wire                                rst_n,
    // APB
    input  wire                                psel,
    input  wire                                penable,
    input  wire                                pwrite,
    input  wire  [3:0]                         paddr,
    input  wire  [31:0]                        pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready,
    // input stream
    input  wire                                s_tvalid,
    output logic                               s_tready,
    input  wire  [utli_pkg::S_TDATA_W-1:0]     s_tdata,  // query_x, entry_index, entry_value
    input  wire  [0:0]                         s_tuser,  // operation
    // result stream
    output logic                               m_tvalid,
    input  wire                                m_tready,
    output logic [utli_pkg::DATA_W-1:0]        m_tdata,  // result_value
    output logic [0:0]                         m_tuser   // in_range
);
    import utli_pkg::*;

    utli_cfg_t  cfg_reg;
    logic       cfg_wr;
    logic [1:0] reg_sel;
    logic       in_range;

    assign pready  = 1'b1;
    assign reg_sel = paddr[3:2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.lower_bound  <= LOWER_BOUND_RST;
            cfg_reg.upper_bound  <= UPPER_BOUND_RST;
            cfg_reg.table_size   <= TABLE_SIZE_RST;
            cfg_reg.step_inverse <= STEP_INVERSE_RST;
        end
        else if (cfg_wr)
        begin
            unique case (reg_sel)
                REG_LOWER_BOUND:  cfg_reg.lower_bound  <= pwdata;
                REG_UPPER_BOUND:  cfg_reg.upper_bound  <= pwdata;
                REG_TABLE_SIZE:   cfg_reg.table_size   <= pwdata[SIZE_W-1:0];
                REG_STEP_INVERSE: cfg_reg.step_inverse <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_sel)
            REG_LOWER_BOUND:  prdata = cfg_reg.lower_bound;
            REG_UPPER_BOUND:  prdata = cfg_reg.upper_bound;
            REG_TABLE_SIZE:   prdata = 32'(cfg_reg.table_size);
            REG_STEP_INVERSE: prdata = cfg_reg.step_inverse;
            default:          prdata = '0;
        endcase
    end

    utli_core u_core
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg            (cfg_reg),
        .s_valid        (s_tvalid),
        .s_ready        (s_tready),
        .s_op           (s_tuser[0]),
        .s_query_x      (s_tdata[DATA_W-1:0]),
        .s_entry_index  (s_tdata[DATA_W+ENTRY_IDX_W-1:DATA_W]),
        .s_entry_value  (s_tdata[S_FIELDS_W-1:DATA_W+ENTRY_IDX_W]),
        .m_valid        (m_tvalid),
        .m_ready        (m_tready),
        .m_result_value (m_tdata),
        .m_in_range     (in_range)
    );

    assign m_tuser = in_range;

endmodule
`default_nettype wire

/* hdl/utli_core.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// utli_core
// Pipelined datapath: range check, grid position multiply, sample memory
// read/write (one write, two read ports), linear blend and output register.
// ----------------------------------------------------------------------------
module utli_core
(
    input  wire                              clk,
    input  wire                              rst_n,
    input  utli_pkg::utli_cfg_t              cfg,
    input  wire                              s_valid,
    output logic                             s_ready,
    input  wire                              s_op,
    input  wire  [utli_pkg::DATA_W-1:0]      s_query_x,
    input  wire  [utli_pkg::ENTRY_IDX_W-1:0] s_entry_index,
    input  wire  [utli_pkg::DATA_W-1:0]      s_entry_value,
    output logic                             m_valid,
    input  wire                              m_ready,
    output logic [utli_pkg::DATA_W-1:0]      m_result_value,
    output logic                             m_in_range
);
    import utli_pkg::*;

    // sample store, undefined until written
    logic [DATA_W-1:0] sample_mem [TABLE_DEPTH];

    // stage valids
    logic va_reg, vb_reg, vc_reg, vd_reg, vo_reg;
    logic en_a, en_b, en_c, en_d, en_o;

    // stage A: range check and offset
    logic                   op_a_reg;
    logic                   inr_a_reg;
    logic [DATA_W-1:0]      d_a_reg;
    logic [ENTRY_IDX_W-1:0] widx_a_reg;
    logic [DATA_W-1:0]      wval_a_reg;

    // stage B: grid position
    logic                   op_b_reg;
    logic                   inr_b_reg;
    logic [2*DATA_W-1:0]    p_b_reg;
    logic [ENTRY_IDX_W-1:0] widx_b_reg;
    logic [DATA_W-1:0]      wval_b_reg;

    // stage C: samples read
    logic                   inr_c_reg;
    logic                   sat_c_reg;
    logic [FRAC_W-1:0]      f_c_reg;
    logic [DATA_W-1:0]      y0_c_reg;
    logic [DATA_W-1:0]      y1_c_reg;

    // stage D: blend product
    logic                   inr_d_reg;
    logic                   sat_d_reg;
    logic [DATA_W-1:0]      y0_d_reg;
    logic signed [DATA_W+FRAC_W+1:0] prod_d_reg;

    // output
    logic [DATA_W-1:0]      result_reg;
    logic                   in_range_reg;

    logic signed [DATA_W-1:0]   x_s;
    logic                       inr_next;
    logic [DATA_W-1:0]          d_next;
    logic [2*DATA_W-1:0]        p_next;
    logic [SIZE_W-1:0]          size_clamped;
    logic [IDX_W-1:0]           last_idx;
    logic [DATA_W-1:0]          grid_idx;
    logic                       sat_next;
    logic [IDX_W-1:0]           addr0;
    logic [IDX_W-1:0]           addr1;
    logic                       wr_en;
    logic signed [DATA_W:0]     diff_s;
    logic signed [DATA_W+FRAC_W+1:0] prod_next;
    logic [DATA_W-1:0]          sum_next;
    logic [DATA_W-1:0]          result_next;

    // stall chain: a stage advances when empty or when the next one advances
    assign en_o    = !vo_reg || m_ready;
    assign en_d    = !vd_reg || en_o;
    assign en_c    = !vc_reg || en_d;
    assign en_b    = !vb_reg || en_c;
    assign en_a    = !va_reg || en_b;
    assign s_ready = en_a;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
            vc_reg <= 1'b0;
            vd_reg <= 1'b0;
            vo_reg <= 1'b0;
        end
        else
        begin
            if (en_a)
                va_reg <= s_valid;
            if (en_b)
                vb_reg <= va_reg;
            // drop write items once they have updated the memory
            if (en_c)
                vc_reg <= vb_reg && (op_b_reg == OP_QUERY);
            if (en_d)
                vd_reg <= vc_reg;
            if (en_o)
                vo_reg <= vd_reg;
        end
    end

    // stage A
    always_comb
    begin
        x_s      = $signed(s_query_x);
        inr_next = (x_s >= cfg.lower_bound) && (x_s <= cfg.upper_bound);
        d_next   = s_query_x - cfg.lower_bound;
    end

    always_ff @(posedge clk)
    begin
        if (en_a)
        begin
            op_a_reg   <= s_op;
            inr_a_reg  <= inr_next;
            d_a_reg    <= d_next;
            widx_a_reg <= s_entry_index;
            wval_a_reg <= s_entry_value;
        end
    end

    // stage B
    assign p_next = 64'(d_a_reg) * 64'(cfg.step_inverse);

    always_ff @(posedge clk)
    begin
        if (en_b)
        begin
            op_b_reg   <= op_a_reg;
            inr_b_reg  <= inr_a_reg;
            p_b_reg    <= p_next;
            widx_b_reg <= widx_a_reg;
            wval_b_reg <= wval_a_reg;
        end
    end

    // stage C: read both neighbors, or perform the write, in item order
    always_comb
    begin
        size_clamped = cfg.table_size;
        if (32'(cfg.table_size) < 32'd2)
            size_clamped = SIZE_W'(2);
        else if (32'(cfg.table_size) > 32'(TABLE_DEPTH))
            size_clamped = SIZE_W'(TABLE_DEPTH);
        last_idx = IDX_W'(size_clamped - SIZE_W'(1));
        grid_idx = p_b_reg[2*DATA_W-1:DATA_W];
        sat_next = grid_idx >= DATA_W'(last_idx);
        addr0    = sat_next ? last_idx : grid_idx[IDX_W-1:0];
        addr1    = addr0 + IDX_W'(1);
        wr_en    = en_c && vb_reg && (op_b_reg == OP_WRITE)
                   && (32'(widx_b_reg) < 32'(TABLE_DEPTH));
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            sample_mem[IDX_W'(widx_b_reg)] <= wval_b_reg;
        if (en_c)
        begin
            y0_c_reg  <= sample_mem[addr0];
            y1_c_reg  <= sample_mem[addr1];
            inr_c_reg <= inr_b_reg;
            sat_c_reg <= sat_next;
            f_c_reg   <= p_b_reg[DATA_W-1:DATA_W-FRAC_W];
        end
    end

    // stage D: (y1 - y0) * f
    always_comb
    begin
        diff_s    = $signed({y1_c_reg[DATA_W-1], y1_c_reg})
                    - $signed({y0_c_reg[DATA_W-1], y0_c_reg});
        prod_next = diff_s * $signed({1'b0, f_c_reg});
    end

    always_ff @(posedge clk)
    begin
        if (en_d)
        begin
            inr_d_reg  <= inr_c_reg;
            sat_d_reg  <= sat_c_reg;
            y0_d_reg   <= y0_c_reg;
            prod_d_reg <= prod_next;
        end
    end

    // output: 0 when out of range, y0 when saturated, else y0 + floor(product / 2^16)
    always_comb
    begin
        sum_next = y0_d_reg + prod_d_reg[DATA_W+FRAC_W-1:FRAC_W];
        if (!inr_d_reg)
            result_next = '0;
        else if (sat_d_reg)
            result_next = y0_d_reg;
        else
            result_next = sum_next;
    end

    always_ff @(posedge clk)
    begin
        if (en_o)
        begin
            result_reg   <= result_next;
            in_range_reg <= inr_d_reg;
        end
    end

    assign m_valid        = vo_reg;
    assign m_result_value = result_reg;
    assign m_in_range     = in_range_reg;

endmodule
`default_nettype wire
